// ----- rtl/lac_pkg.sv -----
// shared types and constants for the layer compositor
`timescale 1ns / 1ps

package lac_pkg;

  localparam int CH_W    = 8;
  localparam int COLOR_W = 3 * CH_W;
  localparam int ACT_W   = 3;
  localparam int LAYER_W = 3;
  localparam int IDX_W   = 6;
  localparam int OLED_W  = 4;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET       = 3'd0,
    ACT_FILL      = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_CLEAR_ALL = 3'd3,
    ACT_COMPOSE   = 3'd4,
    ACT_COMMIT    = 3'd5
  } act_t;

endpackage

// ----- rtl/lac_if.sv -----
// command and pixel channel interfaces
`timescale 1ns / 1ps

interface lac_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [lac_pkg::ACT_W-1:0]   action;
  logic [lac_pkg::LAYER_W-1:0] layer;
  logic [lac_pkg::IDX_W-1:0]   led_index;
  logic [lac_pkg::CH_W-1:0]    red;
  logic [lac_pkg::CH_W-1:0]    green;
  logic [lac_pkg::CH_W-1:0]    blue;

  modport source (output valid, action, layer, led_index, red, green, blue, input ready);
  modport sink   (input valid, action, layer, led_index, red, green, blue, output ready);
endinterface

interface lac_pix_if;
  logic                       valid;
  logic                       ready;
  logic [lac_pkg::OLED_W-1:0] out_led;
  logic [lac_pkg::CH_W-1:0]   out_red;
  logic [lac_pkg::CH_W-1:0]   out_green;
  logic [lac_pkg::CH_W-1:0]   out_blue;
  logic                       last;
  logic                       commit;

  modport source (output valid, out_led, out_red, out_green, out_blue, last, commit,
                  input ready);
  modport sink   (input valid, out_led, out_red, out_green, out_blue, last, commit,
                  output ready);
endinterface

// ----- rtl/lac_mem.sv -----
// color store: one write port, one registered read port
`timescale 1ns / 1ps

module lac_mem #(
  parameter int AW = 6
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [lac_pkg::COLOR_W-1:0]   wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [lac_pkg::COLOR_W-1:0]   rdata
);

  logic [lac_pkg::COLOR_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lac_ctrl.sv -----
// command sequencer, layer accumulator and pixel output register
`timescale 1ns / 1ps

module lac_ctrl #(
  parameter int LAYER_COUNT = 4,
  parameter int LED_COUNT   = 16,
  parameter int LYR_W       = 2,
  parameter int LED_W       = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  lac_cmd_if.sink                     cmd,
  lac_pix_if.source                   pix,
  output logic                        mem_we,
  output logic [LYR_W+LED_W-1:0]      mem_waddr,
  output logic [lac_pkg::COLOR_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [LYR_W+LED_W-1:0]      mem_raddr,
  input  logic [lac_pkg::COLOR_W-1:0] mem_rdata
);

  localparam int AW = LYR_W + LED_W;

  typedef enum logic [2:0] {
    ST_CLR_ALL,
    ST_IDLE,
    ST_SWEEP,
    ST_COMP_RD,
    ST_COMP_WAIT,
    ST_COMP_OUT
  } state_t;

  state_t                      state;
  logic [AW-1:0]               clr_cnt;
  logic [LYR_W-1:0]            lyr;
  logic [LED_W-1:0]            led;
  logic [lac_pkg::COLOR_W-1:0] fill_color;
  logic                        commit_flag;
  logic                        rd_vld;
  logic [lac_pkg::CH_W-1:0]    acc_r, acc_g, acc_b;
  logic [lac_pkg::CH_W-1:0]    acc_r_next, acc_g_next, acc_b_next;
  logic                        out_vld;

  lac_pkg::act_t               act;
  logic                        accept;
  logic                        layer_ok;
  logic                        led_ok;
  logic                        last_lyr;
  logic                        last_led;
  logic                        out_free;
  logic [lac_pkg::COLOR_W-1:0] cmd_color;

  function automatic logic [lac_pkg::CH_W-1:0] sat_add(
    input logic [lac_pkg::CH_W-1:0] a,
    input logic [lac_pkg::CH_W-1:0] b
  );
    logic [lac_pkg::CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[lac_pkg::CH_W] ? lac_pkg::CH_MAX : s[lac_pkg::CH_W-1:0];
  endfunction

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign act       = lac_pkg::act_t'(cmd.action);
  assign layer_ok  = {1'b0, cmd.layer} < 4'(LAYER_COUNT);
  assign led_ok    = {1'b0, cmd.led_index} < 7'(LED_COUNT);
  assign cmd_color = {cmd.red, cmd.green, cmd.blue};
  assign last_lyr  = (lyr == LYR_W'(LAYER_COUNT - 1));
  assign last_led  = (led == LED_W'(LED_COUNT - 1));
  assign out_free  = !out_vld || pix.ready;

  assign acc_r_next = sat_add(acc_r, mem_rdata[23:16]);
  assign acc_g_next = sat_add(acc_g, mem_rdata[15:8]);
  assign acc_b_next = sat_add(acc_b, mem_rdata[7:0]);

  assign pix.valid = out_vld;

  // write port: clearing pass, layer sweep or single set
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {lyr, led};
    mem_wdata = fill_color;
    if (state == ST_CLR_ALL) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (state == ST_SWEEP) begin
      mem_we = 1'b1;
    end else if (accept && act == lac_pkg::ACT_SET && layer_ok && led_ok) begin
      mem_we    = 1'b1;
      mem_waddr = {cmd.layer[LYR_W-1:0], cmd.led_index[LED_W-1:0]};
      mem_wdata = cmd_color;
    end
  end

  // read port walks the layers of one led
  assign mem_re    = (state == ST_COMP_RD);
  assign mem_raddr = {lyr, led};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR_ALL;
      clr_cnt <= '0;
      rd_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_COMP_RD);
      if (rd_vld) begin
        acc_r <= acc_r_next;
        acc_g <= acc_g_next;
        acc_b <= acc_b_next;
      end
      // the output stage reloads in place when a pixel is ready to go
      if (out_vld && pix.ready && state != ST_COMP_OUT) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        ST_CLR_ALL: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (act) inside
              lac_pkg::ACT_FILL, lac_pkg::ACT_CLEAR: begin
                if (layer_ok) begin
                  lyr        <= cmd.layer[LYR_W-1:0];
                  led        <= '0;
                  fill_color <= (act == lac_pkg::ACT_FILL) ? cmd_color : '0;
                  state      <= ST_SWEEP;
                end
              end
              lac_pkg::ACT_CLEAR_ALL: begin
                clr_cnt <= '0;
                state   <= ST_CLR_ALL;
              end
              lac_pkg::ACT_COMPOSE, lac_pkg::ACT_COMMIT: begin
                lyr         <= '0;
                led         <= '0;
                commit_flag <= (act == lac_pkg::ACT_COMMIT);
                acc_r       <= '0;
                acc_g       <= '0;
                acc_b       <= '0;
                state       <= ST_COMP_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWEEP: begin
          led <= led + LED_W'(1);
          if (last_led) begin
            state <= ST_IDLE;
          end
        end
        ST_COMP_RD: begin
          if (last_lyr) begin
            state <= ST_COMP_WAIT;
          end else begin
            lyr <= lyr + LYR_W'(1);
          end
        end
        ST_COMP_WAIT: begin
          state <= ST_COMP_OUT;
        end
        ST_COMP_OUT: begin
          if (out_free) begin
            out_vld       <= 1'b1;
            pix.out_led   <= lac_pkg::OLED_W'(led);
            pix.out_red   <= acc_r;
            pix.out_green <= acc_g;
            pix.out_blue  <= acc_b;
            pix.last      <= last_led;
            pix.commit    <= commit_flag;
            acc_r         <= '0;
            acc_g         <= '0;
            acc_b         <= '0;
            lyr           <= '0;
            if (last_led) begin
              state <= ST_IDLE;
            end else begin
              led   <= led + LED_W'(1);
              state <= ST_COMP_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (state == ST_CLR_ALL && clr_cnt == '0))
    else $error("reset did not start the clearing pass");

  a_no_write_in_compose: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP_RD || state == ST_COMP_WAIT || state == ST_COMP_OUT) |-> !mem_we)
    else $error("store written during compose");

  a_rd_follows_issue: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == ST_COMP_RD))
    else $error("read data without a read");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP_OUT && out_free && last_led) |=> (state == ST_IDLE && pix.last))
    else $error("frame did not end on the last led");

endmodule

// ----- rtl/rgb_layer_additive_compositor_top.sv -----
// top level of the saturating additive rgb layer compositor
`timescale 1ns / 1ps

// set writes the store as it is taken; fill or clear of a layer sweeps all its leds;
//   clear-all sweeps the whole store
// compose: for each led, one store read per layer, then the saturated sum leaves as
//   one pixel; the next led waits while pix.ready holds the output pixel back
// commands: one at a time, none taken while a sweep or a frame is in progress
// reset: synchronous; a clearing pass writes zero over the whole store,
//   with no command taken until it ends
module rgb_layer_additive_compositor_top #(
  parameter int LAYER_COUNT = 4,
  parameter int LED_COUNT   = 16
) (
  input logic       clk,
  input logic       rst,
  lac_cmd_if.sink   cmd,
  lac_pix_if.source pix
);

  // index widths, at least one bit each
  localparam int LYR_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int AW    = LYR_W + LED_W;

  // store port wiring, address is {layer, led}
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [lac_pkg::COLOR_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [lac_pkg::COLOR_W-1:0] mem_rdata;

  // sequencer: decodes commands, sweeps the store, sums layers per led
  lac_ctrl #(
    .LAYER_COUNT (LAYER_COUNT),
    .LED_COUNT   (LED_COUNT),
    .LYR_W       (LYR_W),
    .LED_W       (LED_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pix       (pix),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // color store, one read and one write per cycle, read data registered
  lac_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- verif/rgb_layer_additive_compositor_top_tb.sv -----
// self-checking testbench for the rgb layer compositor: random commands, frame prediction
`timescale 1ns / 1ps

module rgb_layer_additive_compositor_top_tb;

  localparam int LAYER_COUNT = 4;
  localparam int LED_COUNT   = 16;

  // action codes the package leaves undefined; the block must drop them
  localparam logic [lac_pkg::ACT_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [lac_pkg::ACT_W-1:0] ACT_UNDEF_HI = 3'd7;

  // random commands after the directed ones, and the stretch at the end with no idling
  localparam int RANDOM_ITEMS  = 310;
  localparam int QUIET_TAIL    = 40;
  localparam int SEGMENT_ITEMS = 40;
  // longest silent command is clear-all, which sweeps the whole store
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [lac_pkg::ACT_W-1:0]   action;
    logic [lac_pkg::LAYER_W-1:0] layer;
    logic [lac_pkg::IDX_W-1:0]   led;
    logic [lac_pkg::CH_W-1:0]    red;
    logic [lac_pkg::CH_W-1:0]    green;
    logic [lac_pkg::CH_W-1:0]    blue;
  } cmd_item_t;

  typedef struct {
    logic [lac_pkg::OLED_W-1:0] led;
    logic [lac_pkg::CH_W-1:0]   red;
    logic [lac_pkg::CH_W-1:0]   green;
    logic [lac_pkg::CH_W-1:0]   blue;
    logic                       last;
    logic                       commit;
  } pix_item_t;

  // own copy of the color store plus the pixels still owed by the block
  class composite_checker;
    logic [lac_pkg::COLOR_W-1:0] layer_mem [LAYER_COUNT][LED_COUNT];
    pix_item_t                   pending_pixels[$];
    int                          mismatches;

    function new();
      wipe_all();
      mismatches = 0;
    endfunction

    function void wipe_all();
      foreach (layer_mem[k, i]) layer_mem[k][i] = '0;
    endfunction

    // saturating sum of one channel of one led over every layer
    function logic [lac_pkg::CH_W-1:0] blend_channel(int led, int shift);
      int acc;
      acc = 0;
      for (int k = 0; k < LAYER_COUNT; k++) begin
        acc += int'((layer_mem[k][led] >> shift) & 24'hff);
        if (acc > int'(lac_pkg::CH_MAX)) acc = int'(lac_pkg::CH_MAX);
      end
      return acc[lac_pkg::CH_W-1:0];
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    // update the store for one accepted command; compose queues a whole frame
    function void note_command(cmd_item_t c);
      logic [lac_pkg::COLOR_W-1:0] color;
      pix_item_t                   px;
      color = {c.red, c.green, c.blue};
      case (c.action)
        lac_pkg::ACT_SET: begin
          if (c.layer < LAYER_COUNT && c.led < LED_COUNT) layer_mem[c.layer][c.led] = color;
        end
        lac_pkg::ACT_FILL: begin
          if (c.layer < LAYER_COUNT)
            for (int i = 0; i < LED_COUNT; i++) layer_mem[c.layer][i] = color;
        end
        lac_pkg::ACT_CLEAR: begin
          if (c.layer < LAYER_COUNT)
            for (int i = 0; i < LED_COUNT; i++) layer_mem[c.layer][i] = '0;
        end
        lac_pkg::ACT_CLEAR_ALL: begin
          wipe_all();
        end
        lac_pkg::ACT_COMPOSE, lac_pkg::ACT_COMMIT: begin
          for (int i = 0; i < LED_COUNT; i++) begin
            px.led    = i[lac_pkg::OLED_W-1:0];
            px.red    = blend_channel(i, 16);
            px.green  = blend_channel(i, 8);
            px.blue   = blend_channel(i, 0);
            px.last   = (i == LED_COUNT - 1);
            px.commit = (c.action == lac_pkg::ACT_COMMIT);
            pending_pixels.push_back(px);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_pixel(pix_item_t got);
      pix_item_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel led %0d with no frame pending", got.led));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.led !== want.led)
        report($sformatf("out_led %0d, want %0d", got.led, want.led));
      if (got.red !== want.red)
        report($sformatf("led %0d out_red %h, want %h", want.led, got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("led %0d out_green %h, want %h", want.led, got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("led %0d out_blue %h, want %h", want.led, got.blue, want.blue));
      if (got.last !== want.last)
        report($sformatf("led %0d last %b, want %b", want.led, got.last, want.last));
      if (got.commit !== want.commit)
        report($sformatf("led %0d commit %b, want %b", want.led, got.commit, want.commit));
    endtask
  endclass

  logic clk;
  logic rst;

  lac_cmd_if cmd_if ();
  lac_pix_if pix_if ();

  rgb_layer_additive_compositor_top #(
    .LAYER_COUNT(LAYER_COUNT),
    .LED_COUNT  (LED_COUNT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .pix(pix_if)
  );

  composite_checker frames = new();

  // idle chances in percent, changed per segment by the stimulus process
  int gap_pct   = 0;
  int stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest correct run (about 1 ms)
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  // pixel side: check every transfer, then pick ready for the next edge
  initial begin
    int        stall_left;
    pix_item_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
        got.led    = pix_if.out_led;
        got.red    = pix_if.out_red;
        got.green  = pix_if.out_green;
        got.blue   = pix_if.out_blue;
        got.last   = pix_if.last;
        got.commit = pix_if.commit;
        frames.check_pixel(got);
      end
      if (rst) begin
        pix_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pix_if.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
        // start a burst of low ready, this one included; stall_left holds the rest
        stall_left = $urandom_range(10, 1) - 1;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // one command transfer, with an optional idle burst ahead of it
  task automatic send_cmd(input cmd_item_t c);
    int idle;
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      idle = $urandom_range(10, 1);
      cmd_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.action    <= c.action;
    cmd_if.layer     <= c.layer;
    cmd_if.led_index <= c.led;
    cmd_if.red       <= c.red;
    cmd_if.green     <= c.green;
    cmd_if.blue      <= c.blue;
    // valid is already high at the next edge, so ready alone decides the transfer
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    frames.note_command(c);
  endtask

  task automatic put(input logic [lac_pkg::ACT_W-1:0] action, input int layer, input int led,
                     input logic [lac_pkg::CH_W-1:0] red, input logic [lac_pkg::CH_W-1:0] green,
                     input logic [lac_pkg::CH_W-1:0] blue);
    cmd_item_t c;
    c.action = action;
    c.layer  = layer[lac_pkg::LAYER_W-1:0];
    c.led    = led[lac_pkg::IDX_W-1:0];
    c.red    = red;
    c.green  = green;
    c.blue   = blue;
    send_cmd(c);
  endtask

  // mostly small values so sums of four layers often stay below saturation
  function automatic logic [lac_pkg::CH_W-1:0] random_channel();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 40) return lac_pkg::CH_W'($urandom_range(63, 0));
    if (pick < 65) return lac_pkg::CH_W'($urandom_range(255, 0));
    if (pick < 80) return '0;
    if (pick < 90) return lac_pkg::CH_MAX;
    return lac_pkg::CH_W'($urandom_range(255, 128));
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t c;
    int        pick;
    pick = $urandom_range(99, 0);
    if (pick < 34)      c.action = lac_pkg::ACT_SET;
    else if (pick < 50) c.action = lac_pkg::ACT_FILL;
    else if (pick < 57) c.action = lac_pkg::ACT_CLEAR;
    else if (pick < 60) c.action = lac_pkg::ACT_CLEAR_ALL;
    else if (pick < 78) c.action = lac_pkg::ACT_COMPOSE;
    else if (pick < 92) c.action = lac_pkg::ACT_COMMIT;
    else c.action = lac_pkg::ACT_W'($urandom_range(ACT_UNDEF_HI, ACT_UNDEF_LO));
    // roughly one in ten layer or led indexes lands out of range
    if ($urandom_range(9, 0) == 0)
      c.layer = lac_pkg::LAYER_W'($urandom_range(7, LAYER_COUNT));
    else
      c.layer = lac_pkg::LAYER_W'($urandom_range(LAYER_COUNT - 1, 0));
    if ($urandom_range(9, 0) == 0)
      c.led = lac_pkg::IDX_W'($urandom_range(63, LED_COUNT));
    else
      c.led = lac_pkg::IDX_W'($urandom_range(LED_COUNT - 1, 0));
    c.red   = random_channel();
    c.green = random_channel();
    c.blue  = random_channel();
    return c;
  endfunction

  // stimulus: reset, directed commands, then random segments and a quiet tail
  initial begin
    cmd_item_t c;
    int        sent;

    rst              = 1'b1;
    cmd_if.valid     = 1'b0;
    cmd_if.action    = '0;
    cmd_if.layer     = '0;
    cmd_if.led_index = '0;
    cmd_if.red       = '0;
    cmd_if.green     = '0;
    cmd_if.blue      = '0;
    pix_if.ready     = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // the block clears its store after reset; send_cmd simply waits on ready

    gap_pct   = 20;
    stall_pct = 20;

    // empty store composes to black
    put(lac_pkg::ACT_COMPOSE, 0, 0, 8'h00, 8'h00, 8'h00);
    // corners of the store
    put(lac_pkg::ACT_SET, 0, 0, 8'hff, 8'hff, 8'hff);
    put(lac_pkg::ACT_SET, LAYER_COUNT - 1, LED_COUNT - 1, 8'h01, 8'h80, 8'hff);
    // layer out of range, led out of range: both dropped
    put(lac_pkg::ACT_SET, LAYER_COUNT, 0, 8'haa, 8'h55, 8'haa);
    put(lac_pkg::ACT_SET, 7, 63, 8'h55, 8'haa, 8'h55);
    put(lac_pkg::ACT_SET, 0, LED_COUNT, 8'h12, 8'h34, 8'h56);
    // two fills that sum to exactly full scale
    put(lac_pkg::ACT_FILL, 1, 63, 8'h80, 8'h80, 8'h80);
    put(lac_pkg::ACT_FILL, 2, 0, 8'h7f, 8'h7f, 8'h7f);
    put(lac_pkg::ACT_FILL, 5, 0, 8'hff, 8'hff, 8'hff);
    put(lac_pkg::ACT_COMPOSE, 7, 63, 8'hff, 8'hff, 8'hff);
    // push every channel into saturation
    put(lac_pkg::ACT_FILL, 3, 17, 8'hff, 8'h00, 8'h01);
    put(lac_pkg::ACT_FILL, 0, 0, 8'hff, 8'hff, 8'hff);
    put(lac_pkg::ACT_COMMIT, 0, 0, 8'h00, 8'h00, 8'h00);
    put(lac_pkg::ACT_CLEAR, 2, 40, 8'hff, 8'hff, 8'hff);
    put(lac_pkg::ACT_CLEAR, 6, 0, 8'h00, 8'h00, 8'h00);
    put(lac_pkg::ACT_CLEAR, 0, 0, 8'h00, 8'h00, 8'h00);
    // undefined actions
    put(ACT_UNDEF_LO, 0, 0, 8'hff, 8'hff, 8'hff);
    put(ACT_UNDEF_HI, 7, 63, 8'hff, 8'hff, 8'hff);
    put(lac_pkg::ACT_COMPOSE, 0, 0, 8'h00, 8'h00, 8'h00);
    // clear-all ignores whatever sits in the other fields
    put(lac_pkg::ACT_CLEAR_ALL, 7, 63, 8'hff, 8'hff, 8'hff);
    put(lac_pkg::ACT_COMMIT, 7, 63, 8'hff, 8'hff, 8'hff);
    put(lac_pkg::ACT_SET, 2, 7, 8'h00, 8'hff, 8'h00);
    put(lac_pkg::ACT_COMPOSE, 0, 0, 8'h00, 8'h00, 8'h00);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // new idle mix per segment, none at all in the tail
      if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (sent % SEGMENT_ITEMS == 0) begin
        case ($urandom_range(2, 0))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(2, 0))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      c = random_command();
      send_cmd(c);
      sent++;
    end
    cmd_if.valid <= 1'b0;

    // drain the last frame, then leave room for stray pixels to show up
    while (frames.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (frames.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
